// ===== design/wsf_pkg.sv =====
// Package for the 3x3 window filter: shared types, register codes and constants.
// No dependencies; imported by every module of the block.
package wsf_pkg;

  localparam int PIX_W      = 8;
  localparam int IDX_W      = 18;
  localparam int POS_W      = 12;   // row or column position, up to 4095
  localparam int DIM_W      = 13;   // width or height in use, up to 4096
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int MIN_DIM    = 3;
  localparam int ITEM_DEPTH = 4;    // queue between front and back
  localparam int OUT_DEPTH  = 8;    // result queue, power of two

  localparam logic MODE_BLUR  = 1'b0;
  localparam logic MODE_SOBEL = 1'b1;

  localparam logic              RST_MODE   = MODE_SOBEL;
  localparam logic [PIX_W-1:0]  RST_THRESH = 8'd60;
  localparam logic [CFG_W-1:0]  RST_WIDTH  = 10'd320;
  localparam logic [CFG_W-1:0]  RST_HEIGHT = 10'd240;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // floor(s/9) = (s * 7282) >> 16 for every window sum s <= 9*255
  localparam logic [12:0] DIV9_MUL   = 13'd7282;
  localparam int          DIV9_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic             mode;
    pix_t             thresh;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    win_t             win;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             interior;
    logic             border;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    pix_t             value;
    logic             last;
  } result_t;

endpackage

// ===== design/wsf_front.sv =====
// Front part: raster position tracking, the two line stores and the 3x3 window.
// Classifies each pixel as interior and/or border. Depends on wsf_pkg.
module wsf_front import wsf_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       take_i,
  input  pix_t       pixel_i,
  input  logic       frame_start_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [DIM_W-1:0] c_pre, r_pre;
  logic [CW-1:0]    rd_addr;
  logic             interior, border;

  pix_t upper_mem [MAX_WIDTH];
  pix_t lower_mem [MAX_WIDTH];

  logic             s1_v_q;
  pix_t             s1_px_q;
  logic [CW-1:0]    s1_col_q;
  logic [RW-1:0]    s1_row_q;
  logic             s1_interior_q, s1_border_q;
  pix_t             up_rd_q, lo_rd_q;
  logic             fwd_q;
  pix_t             fwd_up_q, fwd_lo_q;
  pix_t             up_val, lo_val;
  win_t             window_q, window_d;

  // Position of the incoming pixel, and where the next one lands
  always_comb begin
    if (frame_start_i) begin
      c_pre = '0;
      r_pre = '0;
    end else if (DIM_W'(col_q) >= cfg_i.width) begin
      c_pre = '0;
      r_pre = DIM_W'(row_q) + DIM_W'(1);
    end else begin
      c_pre = DIM_W'(col_q);
      r_pre = DIM_W'(row_q);
    end
    if (r_pre >= cfg_i.height) begin
      r_pre = '0;
    end

    if (c_pre + DIM_W'(1) >= cfg_i.width) begin
      col_d = '0;
      row_d = (r_pre + DIM_W'(1) >= cfg_i.height) ? '0 : RW'(r_pre + DIM_W'(1));
    end else begin
      col_d = CW'(c_pre + DIM_W'(1));
      row_d = RW'(r_pre);
    end

    rd_addr  = CW'(c_pre);
    interior = (r_pre >= DIM_W'(2)) && (c_pre >= DIM_W'(2));
    border   = (r_pre == '0) || (r_pre == cfg_i.height - DIM_W'(1)) ||
               (c_pre == '0) || (c_pre == cfg_i.width - DIM_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= take_i;
      if (take_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Line stores: read at accept, write back in the cycle after
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      upper_mem[s1_col_q] <= lo_val;
      lower_mem[s1_col_q] <= s1_px_q;
    end
    if (take_i) begin
      up_rd_q <= upper_mem[rd_addr];
      lo_rd_q <= lower_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_px_q       <= pixel_i;
      s1_col_q      <= rd_addr;
      s1_row_q      <= RW'(r_pre);
      s1_interior_q <= interior;
      s1_border_q   <= border;
      // same column written in this cycle: the read sees stale data, so bypass
      fwd_q         <= s1_v_q && (s1_col_q == rd_addr);
      fwd_up_q      <= lo_val;
      fwd_lo_q      <= s1_px_q;
    end
  end

  assign up_val = fwd_q ? fwd_up_q : up_rd_q;
  assign lo_val = fwd_q ? fwd_lo_q : lo_rd_q;

  always_comb begin
    window_d[0] = window_q[1];
    window_d[1] = window_q[2];
    window_d[2] = up_val;
    window_d[3] = window_q[4];
    window_d[4] = window_q[5];
    window_d[5] = lo_val;
    window_d[6] = window_q[7];
    window_d[7] = window_q[8];
    window_d[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (s1_v_q) begin
      window_q <= window_d;
    end
  end

  assign item_valid_o      = s1_v_q;
  assign item_o.win        = window_d;
  assign item_o.col        = POS_W'(s1_col_q);
  assign item_o.row        = POS_W'(s1_row_q);
  assign item_o.interior   = s1_interior_q;
  assign item_o.border     = s1_border_q;

endmodule

// ===== design/wsf_queue.sv =====
// Small first-in first-out queue of classified window items.
// Sits between the front and back parts. Depends on wsf_pkg.
module wsf_queue import wsf_pkg::*; #(
  parameter type T     = item_t,
  parameter int  DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  T                           data_i,
  input  logic                       pop_i,
  output T                           data_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [NW-1:0] cnt_q;
  logic          do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      cnt_q <= cnt_q + NW'(push_i) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== design/wsf_back.sv =====
// Back part: box blur or Sobel arithmetic, result indices and the result queue.
// Turns each window item into zero, one or two result items. Depends on wsf_pkg.
module wsf_back import wsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             item_valid_i,
  input  item_t            item_i,
  output logic             item_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [IDX_W-1:0] pixel_index_o,
  output pix_t             pixel_value_o,
  output logic             run_last_o
);

  localparam int OPW = $clog2(OUT_DEPTH);
  localparam int ONW = $clog2(OUT_DEPTH + 1);
  localparam int RWW = POS_W + DIM_W;
  localparam int KW  = RWW + 1;

  function automatic logic signed [10:0] sext(input pix_t p);
    sext = $signed({3'b000, p});
  endfunction

  logic                 launch;
  logic [ONW:0]         need;
  logic [11:0]          sum;
  logic signed [10:0]   gx, gy;

  logic                 b1_v_q;
  logic [11:0]          b1_sum_q;
  logic signed [10:0]   b1_gx_q, b1_gy_q;
  logic [RWW-1:0]       b1_rw_q;
  logic [POS_W-1:0]     b1_col_q;
  logic                 b1_interior_q, b1_border_q;

  logic [24:0]          div_prod;
  pix_t                 blur, sobel, value;
  logic [10:0]          ax, ay;
  logic [11:0]          mag;
  pix_t                 clip;
  logic [KW-1:0]        k_full, k_int;
  result_t              r_int, r_bord, first;
  logic [1:0]           n_res;

  result_t              out_q [OUT_DEPTH];
  logic [OPW-1:0]       wp_q, rp_q;
  logic [ONW-1:0]       cnt_q;
  logic                 do_pop;

  // Reserve room for two results per item in flight before taking another
  assign need   = ONW'(cnt_q) + (b1_v_q ? (ONW+1)'(2) : '0) + (ONW+1)'(2);
  assign launch = item_valid_i && (need <= (ONW+1)'(OUT_DEPTH));
  assign item_pop_o = launch;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + 12'(item_i.win[i]);
    end
    gx = (sext(item_i.win[2]) - sext(item_i.win[0])) +
         ((sext(item_i.win[5]) - sext(item_i.win[3])) <<< 1) +
         (sext(item_i.win[8]) - sext(item_i.win[6]));
    gy = (sext(item_i.win[6]) - sext(item_i.win[0])) +
         ((sext(item_i.win[7]) - sext(item_i.win[1])) <<< 1) +
         (sext(item_i.win[8]) - sext(item_i.win[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
    end else begin
      b1_v_q <= launch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      b1_sum_q      <= sum;
      b1_gx_q       <= gx;
      b1_gy_q       <= gy;
      b1_rw_q       <= item_i.row * cfg_i.width;
      b1_col_q      <= item_i.col;
      b1_interior_q <= item_i.interior;
      b1_border_q   <= item_i.border;
    end
  end

  always_comb begin
    div_prod = b1_sum_q * DIV9_MUL;
    blur     = div_prod[DIV9_SHIFT +: PIX_W];

    ax    = (b1_gx_q < 0) ? 11'(-b1_gx_q) : 11'(b1_gx_q);
    ay    = (b1_gy_q < 0) ? 11'(-b1_gy_q) : 11'(b1_gy_q);
    mag   = 12'(ax) + 12'(ay);
    clip  = (mag > 12'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];
    sobel = (clip >= cfg_i.thresh) ? clip : '0;
    value = (cfg_i.mode == MODE_BLUR) ? blur : sobel;

    k_full = KW'(b1_rw_q) + KW'(b1_col_q);
    k_int  = k_full - KW'(cfg_i.width) - KW'(1);

    r_int.index  = IDX_W'(k_int);
    r_int.value  = value;
    r_int.last   = !b1_border_q;
    r_bord.index = IDX_W'(k_full);
    r_bord.value = '0;
    r_bord.last  = 1'b1;

    first = b1_interior_q ? r_int : r_bord;
    n_res = b1_v_q ? (2'(b1_interior_q) + 2'(b1_border_q)) : 2'd0;
  end

  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + OPW'(n_res);
      cnt_q <= cnt_q + ONW'(n_res) - ONW'(do_pop);
      if (do_pop) begin
        rp_q <= rp_q + OPW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      out_q[wp_q] <= first;
    end
    if (n_res == 2'd2) begin
      out_q[wp_q + OPW'(1)] <= r_bord;
    end
  end

  assign pixel_index_o = out_q[rp_q].index;
  assign pixel_value_o = out_q[rp_q].value;
  assign run_last_o    = out_q[rp_q].last;

endmodule

// ===== design/window_3x3_blur_sobel_filter.sv =====
// Top level of the 3x3 window filter (box blur or thresholded Sobel edges).
// Holds the configuration registers; instantiates wsf_front, wsf_queue, wsf_back.
//
//   channel   handshake         payload
//   input     push_i / full_o   pixel_i, frame_start_i
//   result    empty_o / pop_i   pixel_index_o, pixel_value_o, run_last_o
//   config    cfg_we_i          cfg_index_i, cfg_data_i
//
// One pixel is accepted per clock unless full_o is high; the line stores take one
// read and one write per cycle, which sets that rate. Pixels that give two
// results drain at one result per cycle through the result queue, so full_o rises
// when pop stalls and also along the last row of a frame, where every pixel from
// column 2 on gives two. Reset clears position, window and queues; the line
// stores are not cleared.
module window_3x3_blur_sobel_filter import wsf_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [PIX_W-1:0]     pixel_i,
  input  logic                 frame_start_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [IDX_W-1:0]     pixel_index_o,
  output logic [PIX_W-1:0]     pixel_value_o,
  output logic                 run_last_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int QNW = $clog2(ITEM_DEPTH + 1);

  logic             mode_q;
  pix_t             thresh_q;
  logic [CFG_W-1:0] width_q, height_q;
  cfg_t             cfg;

  logic             take;
  logic             s1_valid;
  item_t            s1_item;
  logic             q_valid, q_pop;
  item_t            q_item;
  logic [QNW-1:0]   q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_MODE;
      thresh_q <= RST_THRESH;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_THRESH: thresh_q <= cfg_data_i[PIX_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to at least MIN_DIM and at most MAX_WIDTH by MAX_HEIGHT
  always_comb begin
    cfg.mode   = mode_q;
    cfg.thresh = thresh_q;
    if (width_q > MAX_WIDTH) begin
      cfg.width = DIM_W'(MAX_WIDTH);
    end else if (width_q < MIN_DIM) begin
      cfg.width = DIM_W'(MIN_DIM);
    end else begin
      cfg.width = DIM_W'(width_q);
    end
    if (height_q > MAX_HEIGHT) begin
      cfg.height = DIM_W'(MAX_HEIGHT);
    end else if (height_q < MIN_DIM) begin
      cfg.height = DIM_W'(MIN_DIM);
    end else begin
      cfg.height = DIM_W'(height_q);
    end
  end

  // Hold off input while the queue plus the item in flight could overfill it
  assign full_o = ((QNW+1)'(q_count) + (QNW+1)'(s1_valid)) >= (QNW+1)'(ITEM_DEPTH);
  assign take   = push_i && !full_o;

  wsf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .take_i        (take),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .item_valid_o  (s1_valid),
    .item_o        (s1_item)
  );

  wsf_queue #(
    .T     (item_t),
    .DEPTH (ITEM_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid),
    .data_i  (s1_item),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  wsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_pop_o    (q_pop),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .pixel_index_o (pixel_index_o),
    .pixel_value_o (pixel_value_o),
    .run_last_o    (run_last_o)
  );

endmodule

// ===== tb/sv/window_3x3_blur_sobel_filter_test.sv =====
// Testbench for window_3x3_blur_sobel_filter: streams pixel frames and register writes into the
// filter, predicts every result in a scoreboard class and checks the results as they are popped.
// Depends on wsf_pkg and the filter RTL.
module window_3x3_blur_sobel_filter_test import wsf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM      = 512;
  localparam int RANDOM_ITEMS = 500;
  localparam int MIN_PHASES   = 4;
  localparam int WIDE_ITEMS   = 2 * MAX_DIM + 40;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;

  class blur_sobel_scoreboard;
    logic             mode;
    pix_t             thresh;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_t             upper_line [MAX_DIM];
    pix_t             lower_line [MAX_DIM];
    pix_t             win [9];
    int unsigned      col;
    int unsigned      row;
    result_t          awaited [$];
    int               errors;
    int               pixels_taken;
    int               results_checked;

    function new();
      mode       = RST_MODE;
      thresh     = RST_THRESH;
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col             = 0;
      row             = 0;
      errors          = 0;
      pixels_taken    = 0;
      results_checked = 0;
    endfunction

    function void set_reg(cfg_reg_e sel, logic [CFG_W-1:0] data);
      case (sel)
        CFG_MODE:   mode = data[0];
        CFG_THRESH: thresh = data[PIX_W-1:0];
        CFG_WIDTH:  width_reg = data;
        CFG_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned in_use(logic [CFG_W-1:0] data);
      if (data < MIN_DIM) return MIN_DIM;
      if (data > MAX_DIM) return MAX_DIM;
      return data;
    endfunction

    // win[row*3+col]: row 0 is the oldest line, col 2 the newest column
    function pix_t window_filter();
      int p [9];
      int sum;
      int gx;
      int gy;
      int mag;
      foreach (win[i]) p[i] = win[i];
      if (mode == MODE_BLUR) begin
        sum = 0;
        foreach (p[i]) sum += p[i];
        return pix_t'(sum / 9);
      end
      gx  = (p[2] - p[0]) + 2 * (p[5] - p[3]) + (p[8] - p[6]);
      gy  = (p[6] - p[0]) + 2 * (p[7] - p[1]) + (p[8] - p[2]);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > 255) mag = 255;
      return (mag >= thresh) ? pix_t'(mag) : '0;
    endfunction

    function void take_pixel(pix_t px, logic fs);
      int unsigned w;
      int unsigned h;
      int          i;
      logic        inner;
      logic        on_border;
      result_t     res;
      w = in_use(width_reg);
      h = in_use(height_reg);
      if (fs) begin
        col = 0;
        row = 0;
      end else if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      for (i = 0; i < 9; i += 3) begin
        win[i]   = win[i+1];
        win[i+1] = win[i+2];
      end
      win[2]          = upper_line[col];
      win[5]          = lower_line[col];
      upper_line[col] = lower_line[col];
      lower_line[col] = px;
      win[8]          = px;

      inner     = (row >= 2) && (col >= 2);
      on_border = (row == 0) || (row == h - 1) || (col == 0) || (col == w - 1);
      if (inner) begin
        res.index = IDX_W'((row - 1) * w + col - 1);
        res.value = window_filter();
        res.last  = !on_border;
        awaited.push_back(res);
      end
      if (on_border) begin
        res.index = IDX_W'(row * w + col);
        res.value = '0;
        res.last  = 1'b1;
        awaited.push_back(res);
      end

      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
      pixels_taken++;
    endfunction

    function void match_result(logic [IDX_W-1:0] idx, pix_t value, logic last);
      result_t exp_res;
      results_checked++;
      if (awaited.size() == 0) begin
        $error("result at index %0d arrived with nothing awaited", idx);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      if (idx !== exp_res.index) begin
        $error("pixel_index: expected %0d, got %0d", exp_res.index, idx);
        errors++;
      end
      if (value !== exp_res.value) begin
        $error("pixel_value: expected %0d, got %0d", exp_res.value, value);
        errors++;
      end
      if (last !== exp_res.last) begin
        $error("run_last: expected %0d, got %0d", exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 push_i        = 1'b0;
  logic                 full_o;
  logic [PIX_W-1:0]     pixel_i       = '0;
  logic                 frame_start_i = 1'b0;
  logic                 empty_o;
  logic                 pop_i         = 1'b0;
  logic [IDX_W-1:0]     pixel_index_o;
  logic [PIX_W-1:0]     pixel_value_o;
  logic                 run_last_o;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  blur_sobel_scoreboard board = new();

  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;
  int          hold_left     = 0;
  int          hold_requests = 0;
  int          holds_started = 0;
  int unsigned cycles        = 0;

  window_3x3_blur_sobel_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .pixel_index_o (pixel_index_o),
    .pixel_value_o (pixel_value_o),
    .run_last_o    (run_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("run timed out after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) board.take_pixel(pixel_i, frame_start_i);
      if (pop_i && !empty_o) board.match_result(pixel_index_o, pixel_value_o, run_last_o);
    end
  end

  // receiver: a hold-off counts down first, then pop at the stall rate in force
  always @(negedge clk_i) begin
    if (holds_started != hold_requests) begin
      holds_started = hold_requests;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(input pix_t px, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i        <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] mode_d, thresh_d, width_d, height_d);
    cfg_reg_e         sel [4];
    logic [CFG_W-1:0] vals [4];
    int               i;
    sel  = '{CFG_MODE, CFG_THRESH, CFG_WIDTH, CFG_HEIGHT};
    vals = '{mode_d, thresh_d, width_d, height_d};
    for (i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= sel[i];
      cfg_data_i  <= vals[i];
      board.set_reg(sel[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // drain: every awaited result in, then let items that give no result leave the pipe
  task automatic wait_idle();
    push_i <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic pix_t pick_pixel(pix_t prev);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return PIX_MAX;
    // small steps give Sobel magnitudes around the threshold
    if (sel < 6) return prev + pix_t'($urandom_range(16)) - 8'd8;
    return pix_t'($urandom_range(255));
  endfunction

  task automatic run_frames(input int count, input logic force_start);
    pix_t px;
    logic fs;
    int   i;
    px = pix_t'($urandom_range(255));
    for (i = 0; i < count; i++) begin
      px = pick_pixel(px);
      fs = (i == 0 && force_start) || ($urandom_range(149) == 0);
      send_pixel(px, fs);
    end
  endtask

  initial begin
    int               i;
    int               phase;
    int               count;
    int               random_sent;
    int unsigned      old_w;
    logic [CFG_W-1:0] w_d;
    logic [CFG_W-1:0] h_d;
    logic [CFG_W-1:0] t_d;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // hard vertical edge, threshold 0, so flat windows give 0 and the edge clips
    write_regs(CFG_W'(MODE_SOBEL), 10'd0, 10'd5, 10'd3);
    for (i = 0; i < 15; i++) send_pixel((i % 5 < 2) ? 8'd0 : PIX_MAX, i == 0);
    repeat (4) send_pixel(PIX_MAX, 1'b0);
    wait_idle();

    // width below the minimum with the column already past it; unused upper bits set
    write_regs(10'h3FE, 10'h3FF, 10'd2, 10'h3FF);
    repeat (6) send_pixel(PIX_MAX, 1'b0);
    wait_idle();

    // widest frame, clamped from above, deep enough to reach interior rows
    write_regs(CFG_W'(MODE_SOBEL), 10'd100, 10'h3FF, 10'd4);
    run_frames(WIDE_ITEMS, 1'b1);
    wait_idle();

    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS || phase < MIN_PHASES) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 67; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 67; end
        default: begin send_idle_pct = 16; pop_stall_pct = 16; end
      endcase
      case ($urandom_range(9))
        0: w_d = CFG_W'($urandom_range(2));
        1: w_d = CFG_W'($urandom_range(1023, 513));
        2: w_d = CFG_W'($urandom_range(40, 13));
        default: w_d = CFG_W'($urandom_range(12, 3));
      endcase
      case ($urandom_range(9))
        0, 1: h_d = CFG_W'($urandom_range(2));
        2, 3: h_d = CFG_W'($urandom_range(20, 7));
        4: h_d = CFG_W'($urandom_range(1023, 500));
        default: h_d = CFG_W'($urandom_range(6, 3));
      endcase
      case ($urandom_range(3))
        0: t_d = '0;
        1: t_d = 10'd255;
        default: t_d = CFG_W'($urandom());
      endcase
      old_w = board.in_use(board.width_reg);
      write_regs(CFG_W'($urandom()), t_d, w_d, h_d);
      // hold off the receiver so the result queue fills and push stalls
      if (phase % 8 == 0) begin
        @(posedge clk_i);
        hold_requests++;
        @(negedge clk_i);
      end
      count = $urandom_range(220, 60);
      // a wider row must start a new frame so no unwritten line entry is read
      run_frames(count, board.in_use(w_d) > old_w);
      random_sent += count;
      phase++;
      wait_idle();
    end

    $display("Checked %0d results from %0d pixels over %0d register settings,",
             board.results_checked, board.pixels_taken, phase + 3);
    $display("in blur and Sobel modes, widths 3 to 512, with stalls on both sides.");
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== window_3x3_blur_sobel_filter.f =====
design/wsf_pkg.sv
design/wsf_front.sv
design/wsf_queue.sv
design/wsf_back.sv
design/window_3x3_blur_sobel_filter.sv
tb/sv/window_3x3_blur_sobel_filter_test.sv
